// ----- sv/bmp_pkg.sv -----
`timescale 1ns / 1ps
package bmp_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int INDEX_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;
  localparam int RESULT_CAP = 16;
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_SIZE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_SHIFT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SHIFT    = 3'd4;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd320;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd240;
  localparam logic [4:0]  RST_GRID_SIZE    = 5'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic geo_latch;
    logic geo_start;
    logic geo_write;
    logic mem_rd;
    logic acc_write;
    logic rep_rd;
    logic div_start;
    logic out_load;
    logic rep_next;
    logic pos_advance;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic geo_last;
    logic rep_pending;
    logic area_zero;
    logic out_busy;
    logic end_of_frame;
  } dp_stat_t;

endpackage

// ----- sv/bmp_in_if.sv -----
`timescale 1ns / 1ps
interface bmp_in_if import bmp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                frame_start;

  modport source (output valid, output sample, output frame_start, input ready);
  modport sink (input valid, input sample, input frame_start, output ready);
endinterface

// ----- sv/bmp_out_if.sv -----
`timescale 1ns / 1ps
interface bmp_out_if import bmp_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] cell_mean;
  logic [INDEX_W-1:0]  cell_index;
  logic                empty_cell;
  logic                last_in_band;
  logic                last_in_frame;

  modport source (output valid, output cell_mean, output cell_index, output empty_cell,
                  output last_in_band, output last_in_frame, input ready);
  modport sink (input valid, input cell_mean, input cell_index, input empty_cell,
                input last_in_band, input last_in_frame, output ready);
endinterface

// ----- sv/bmp_div.sv -----
`timescale 1ns / 1ps
module bmp_div #(
  parameter int NUM_W = 44,
  parameter int DEN_W = 22
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [NUM_W-1:0] quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic [CW-1:0]    cnt;
  logic             busy;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_r;
  logic [DEN_W:0]   trial;
  logic             fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem, quo[NUM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
    end else if (busy) begin
      rem <= fits ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      quo <= {quo[NUM_W-2:0], fits};
    end
  end

endmodule

// ----- sv/bmp_ctrl.sv -----
`timescale 1ns / 1ps
module bmp_ctrl import bmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  input  logic     in_frame_start,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [11:0] {
    S_IDLE   = 12'b000000000001,
    S_GLATCH = 12'b000000000010,
    S_GDIV   = 12'b000000000100,
    S_GWAIT  = 12'b000000001000,
    S_RD     = 12'b000000010000,
    S_ACC    = 12'b000000100000,
    S_CHK    = 12'b000001000000,
    S_RDR    = 12'b000010000000,
    S_DIV    = 12'b000100000000,
    S_DWAIT  = 12'b001000000000,
    S_OWAIT  = 12'b010000000000,
    S_ADV    = 12'b100000000000
  } state_t;

  state_t state, state_next;
  logic   pend, pend_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_GLATCH;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
  end

  always_comb begin
    state_next = state;
    pend_next  = pend;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_frame_start) begin
            pend_next  = 1'b1;
            state_next = S_GLATCH;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_GLATCH: begin
        cmd.geo_latch = 1'b1;
        state_next    = S_GDIV;
      end
      S_GDIV: begin
        cmd.geo_start = 1'b1;
        state_next    = S_GWAIT;
      end
      S_GWAIT: begin
        if (stat.div_done) begin
          cmd.geo_write = 1'b1;
          if (stat.geo_last) begin
            // A pending transaction carried a frame start: go on with its sample.
            state_next = pend ? S_RD : S_IDLE;
            pend_next  = 1'b0;
          end else begin
            state_next = S_GDIV;
          end
        end
      end
      S_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = S_ACC;
      end
      S_ACC: begin
        cmd.acc_write = 1'b1;
        state_next    = S_CHK;
      end
      S_CHK: begin
        state_next = stat.rep_pending ? S_RDR : S_ADV;
      end
      S_RDR: begin
        cmd.rep_rd = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.area_zero) begin
          cmd.out_load = 1'b1;
          cmd.rep_next = 1'b1;
          state_next   = S_OWAIT;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_DWAIT;
        end
      end
      S_DWAIT: begin
        if (stat.div_done) begin
          cmd.out_load = 1'b1;
          cmd.rep_next = 1'b1;
          state_next   = S_OWAIT;
        end
      end
      S_OWAIT: begin
        if (!stat.out_busy) state_next = S_CHK;
      end
      S_ADV: begin
        cmd.pos_advance = 1'b1;
        state_next      = stat.end_of_frame ? S_GLATCH : S_IDLE;
      end
      default: state_next = S_GLATCH;
    endcase
  end

endmodule

// ----- sv/bmp_dp.sv -----
`timescale 1ns / 1ps
module bmp_dp import bmp_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_GRID    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [SAMPLE_W-1:0]   in_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [SAMPLE_W-1:0]   out_mean,
  output logic [INDEX_W-1:0]    out_index,
  output logic                  out_empty,
  output logic                  out_last_band,
  output logic                  out_last_frame,
  input  dp_cmd_t               cmd,
  output dp_stat_t              stat
);

  localparam int MAXD = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DW   = $clog2(MAXD + 1);
  localparam int NW   = $clog2(MAX_GRID + 1);
  localparam int KW   = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int AW   = 2 * DW;
  localparam int SB   = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
  localparam int SW   = SB + 2 * DW;
  localparam int MD   = 1 << (2 * KW);
  localparam int PW   = NW + DW;

  // Configuration registers.
  logic [10:0] cfg_w, cfg_h, cfg_cs, cfg_rs;
  logic [4:0]  cfg_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_w  <= RST_IMAGE_WIDTH;
      cfg_h  <= RST_IMAGE_HEIGHT;
      cfg_n  <= RST_GRID_SIZE;
      cfg_cs <= '0;
      cfg_rs <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  cfg_w  <= cfg_data;
        REG_IMAGE_HEIGHT: cfg_h  <= cfg_data;
        REG_GRID_SIZE:    cfg_n  <= cfg_data[4:0];
        REG_COL_SHIFT:    cfg_cs <= cfg_data;
        REG_ROW_SHIFT:    cfg_rs <= cfg_data;
        default: ;
      endcase
    end
  end

  // Frame geometry from the registers.
  logic [DW-1:0] w_cl, h_cl, ce_c, co_c, re_c, ro_c;
  logic [NW-1:0] n_cl;

  function automatic logic [2*DW-1:0] split_shift(input logic [DW-1:0] ext,
                                                  input logic [10:0] raw);
    logic        neg;
    logic [11:0] mag;
    logic [DW-1:0] m, e, off;
    neg = raw[10];
    mag = neg ? (12'h800 - {1'b0, raw}) : {1'b0, raw};
    m   = (int'(mag) > int'(ext)) ? ext : DW'(mag);
    e   = ext - m;
    off = (!neg && (m != '0)) ? m : '0;
    return {e, off};
  endfunction

  always_comb begin
    w_cl = (cfg_w == '0) ? DW'(1) : ((int'(cfg_w) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(cfg_w));
    h_cl = (cfg_h == '0) ? DW'(1) :
           ((int'(cfg_h) > MAX_HEIGHT) ? DW'(MAX_HEIGHT) : DW'(cfg_h));
    n_cl = (cfg_n == '0) ? NW'(1) : ((int'(cfg_n) > MAX_GRID) ? NW'(MAX_GRID) : NW'(cfg_n));
    {ce_c, co_c} = split_shift(w_cl, cfg_cs);
    {re_c, ro_c} = split_shift(h_cl, cfg_rs);
  end

  logic [DW-1:0] geo_w, geo_h, col_e, col_off, row_e, row_off;
  logic [NW-1:0] geo_n, gi;
  logic          gaxis;
  logic [DW-1:0] col_b [0:MAX_GRID];
  logic [DW-1:0] row_b [0:MAX_GRID];

  logic [DW-1:0] cur_col, cur_row;
  logic [NW-1:0] band, ccol;
  logic [CNT_W-1:0] cnt;
  logic [SB-1:0] smp;

  // Divider shared by boundary and mean computation.
  logic          dv_start, dv_done;
  logic [SW-1:0] dv_num, dv_quo;
  logic [AW-1:0] dv_den;
  logic [PW-1:0] prod;
  logic [AW-1:0] area;
  logic [SW-1:0] rd_data;
  logic          rd_vld;

  assign prod     = PW'(gi) * PW'(gaxis ? row_e : col_e);
  assign dv_start = cmd.geo_start | cmd.div_start;
  assign dv_num   = cmd.geo_start ? SW'(prod) : (rd_vld ? rd_data : '0);
  assign dv_den   = cmd.geo_start ? AW'(geo_n) : area;

  bmp_div #(.NUM_W(SW), .DEN_W(AW)) u_div (
    .clk(clk), .rst(rst), .start(dv_start), .num(dv_num), .den(dv_den),
    .done(dv_done), .quo(dv_quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.geo_latch) begin
      geo_w   <= w_cl;
      geo_h   <= h_cl;
      geo_n   <= n_cl;
      col_e   <= ce_c;
      col_off <= co_c;
      row_e   <= re_c;
      row_off <= ro_c;
    end
    if (cmd.geo_write) begin
      if (gaxis) row_b[gi] <= DW'(dv_quo) + row_off;
      else       col_b[gi] <= DW'(dv_quo) + col_off;
    end
    if (cmd.take) smp <= in_sample[SB-1:0];
  end

  // Cell lookup by comparing the position against every boundary.
  logic [MAX_GRID:0] col_ge, row_ge, row_le;
  logic [DW-1:0]     done_rows;
  logic              col_wrap, in_window;
  logic [KW-1:0]     cell_k, cell_l;
  logic [DW-1:0]     cw [0:MAX_GRID-1];
  logic [DW-1:0]     rw [0:MAX_GRID-1];

  assign col_wrap  = (DW'(cur_col + 1'b1) >= geo_w);
  assign done_rows = cur_row + DW'(col_wrap);

  always_comb begin
    for (int i = 0; i <= MAX_GRID; i++) begin
      col_ge[i] = cur_col >= col_b[i];
      row_ge[i] = cur_row >= row_b[i];
      row_le[i] = row_b[i] <= done_rows;
    end
    for (int i = 0; i < MAX_GRID; i++) begin
      cw[i] = col_b[i+1] - col_b[i];
      rw[i] = row_b[i+1] - row_b[i];
    end
  end

  always_comb begin
    int kc, lc;
    kc = 0;
    lc = 0;
    for (int i = 1; i < MAX_GRID; i++) begin
      if (i < int'(geo_n) && col_ge[i]) kc = kc + 1;
      if (i < int'(geo_n) && row_ge[i]) lc = lc + 1;
    end
    cell_k = KW'(kc);
    cell_l = KW'(lc);
    in_window = col_ge[0] && !col_ge[geo_n] && row_ge[0] && !row_ge[geo_n];
  end

  // Sum store with a valid bit per entry; an entry not yet written reads as zero.
  logic [SW-1:0]   sums [0:MD-1];
  logic [MD-1:0]   vld;
  logic [2*KW-1:0] rd_addr, acc_addr;
  logic            acc_in;

  assign rd_addr = cmd.rep_rd ? {band[KW-1:0], ccol[KW-1:0]} : {cell_l, cell_k};

  always_ff @(posedge clk) begin
    rd_data <= sums[rd_addr];
    if (cmd.acc_write && acc_in)
      sums[acc_addr] <= (rd_vld ? rd_data : '0) + SW'(smp);
    if (cmd.mem_rd) begin
      acc_addr <= rd_addr;
      acc_in   <= in_window;
    end
    if (cmd.rep_rd)
      area <= AW'(rw[band[KW-1:0]]) * AW'(cw[ccol[KW-1:0]]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= vld[rd_addr];
      if (cmd.geo_latch) vld <= '0;
      else if (cmd.acc_write && acc_in) vld[acc_addr] <= 1'b1;
    end
  end

  // Position, report pointers and boundary sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col <= '0;
      cur_row <= '0;
      band    <= '0;
      ccol    <= '0;
      cnt     <= '0;
      gi      <= '0;
      gaxis   <= 1'b0;
    end else begin
      if (cmd.geo_latch) begin
        cur_col <= '0;
        cur_row <= '0;
        band    <= '0;
        ccol    <= '0;
        cnt     <= '0;
        gi      <= '0;
        gaxis   <= 1'b0;
      end
      if (cmd.geo_write) begin
        if (gi == geo_n) begin
          gi    <= '0;
          gaxis <= 1'b1;
        end else begin
          gi <= gi + 1'b1;
        end
      end
      if (cmd.rep_next) begin
        cnt <= cnt + 1'b1;
        if (NW'(ccol + 1'b1) >= geo_n) begin
          ccol <= '0;
          band <= band + 1'b1;
        end else begin
          ccol <= ccol + 1'b1;
        end
      end
      if (cmd.pos_advance) begin
        cnt <= '0;
        if (col_wrap) begin
          cur_col <= '0;
          if (!(DW'(cur_row + 1'b1) >= geo_h)) cur_row <= cur_row + 1'b1;
        end else begin
          cur_col <= cur_col + 1'b1;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_mean       <= (area == '0) ? '0 : SAMPLE_W'(dv_quo);
      out_index      <= INDEX_W'(int'(ccol) * int'(geo_n) + int'(band));
      out_empty      <= (area == '0);
      out_last_band  <= (NW'(ccol + 1'b1) == geo_n);
      out_last_frame <= (NW'(ccol + 1'b1) == geo_n) && (NW'(band + 1'b1) == geo_n);
    end
  end

  always_comb begin
    stat.div_done     = dv_done;
    stat.geo_last     = gaxis && (gi == geo_n);
    stat.rep_pending  = (int'(cnt) < RESULT_CAP) && (band < geo_n) &&
                        ((band < geo_n) ? row_le[NW'(band + 1'b1)] : 1'b0);
    stat.area_zero    = (area == '0);
    stat.out_busy     = out_valid;
    stat.end_of_frame = col_wrap && (DW'(cur_row + 1'b1) >= geo_h);
  end

endmodule

// ----- sv/block_mean_pooling_grid_top.sv -----
`timescale 1ns / 1ps
// NxN block average pooling over a raster-ordered map. The block takes no new sample
// transaction until it is through with the last one. Each cell that a sample completes
// gets its mean from a division unless the cell is empty, and the block waits for as
// long as the receiver holds the result; the divider is a single shared restoring unit
// that produces one quotient bit per cycle.
// At most sixteen cells are reported per sample; the rest follow on later samples.
// At reset and at every frame start, explicit or after the last sample of a frame,
// the same divider computes the 2*(N+1) cell boundaries, and no sample is taken in
// that time. Results wait in an output register until taken; register writes take
// effect at the next frame start.
module block_mean_pooling_grid_top import bmp_pkg::*; #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int MAX_GRID    = 16,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bmp_in_if.sink                samples,
  bmp_out_if.source             cells
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  bmp_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(samples.valid), .in_frame_start(samples.frame_start),
    .in_ready(samples.ready), .stat(stat), .cmd(cmd)
  );

  bmp_dp #(
    .MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_GRID(MAX_GRID), .SAMPLE_BITS(SAMPLE_BITS)
  ) u_dp (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_sample(samples.sample),
    .out_valid(cells.valid), .out_ready(cells.ready),
    .out_mean(cells.cell_mean), .out_index(cells.cell_index),
    .out_empty(cells.empty_cell), .out_last_band(cells.last_in_band),
    .out_last_frame(cells.last_in_frame),
    .cmd(cmd), .stat(stat)
  );

  // A new sample is only taken once every result of the previous one is gone.
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    samples.ready |-> !cells.valid)
    else $error("sample accepted while a result is pending");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.empty_cell |-> cells.cell_mean == '0)
    else $error("empty cell with nonzero mean");

  a_frame_last: assert property (@(posedge clk) disable iff (rst)
    cells.valid && cells.last_in_frame |-> cells.last_in_band)
    else $error("last cell of frame not last of band");

  a_single_load: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !cells.valid)
    else $error("result register overwritten");

endmodule

// ----- dv/block_mean_pooling_grid_checker.sv -----
`timescale 1ns / 1ps
module block_mean_pooling_grid_checker import bmp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bmp_in_if                     in_ch,
  bmp_out_if                    out_ch,
  output int                    fail_count,
  output int                    cells_pending
);

  localparam int GRID_LIM   = 16;
  localparam int WIDTH_LIM  = 1024;
  localparam int HEIGHT_LIM = 1024;

  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [INDEX_W-1:0]  index;
    logic                empty;
    logic                band_end;
    logic                frame_end;
  } cell_report_t;

  cell_report_t report_q[$];

  logic [10:0] reg_width, reg_height, reg_col_shift, reg_row_shift;
  logic [4:0]  reg_grid;
  int unsigned frame_w, frame_h, frame_n;
  int unsigned col_edge[GRID_LIM+1];
  int unsigned row_edge[GRID_LIM+1];
  longint unsigned cell_acc[GRID_LIM*GRID_LIM];
  int unsigned pos_row, pos_col, next_band, next_cell;

  function automatic int unsigned clamp_size(int unsigned v, int unsigned hi);
    if (v == 0) return 1;
    return (v > hi) ? hi : v;
  endfunction

  // Cell edges along one axis, with the window cut by the signed shift.
  function automatic void cut_axis(ref int unsigned edges[GRID_LIM+1], input int unsigned ext,
                                   input logic [10:0] shift, input int unsigned n);
    int unsigned mag, span, offset;
    mag = shift[10] ? (2048 - int'(shift)) : int'(shift);
    if (mag > ext) mag = ext;
    span = ext - mag;
    offset = (!shift[10] && mag != 0) ? mag : 0;
    for (int i = 0; i <= n; i++) edges[i] = (i * span) / n + offset;
  endfunction

  function automatic void restart_frame();
    frame_w = clamp_size(reg_width, WIDTH_LIM);
    frame_h = clamp_size(reg_height, HEIGHT_LIM);
    frame_n = clamp_size(reg_grid, GRID_LIM);
    cut_axis(col_edge, frame_w, reg_col_shift, frame_n);
    cut_axis(row_edge, frame_h, reg_row_shift, frame_n);
    foreach (cell_acc[i]) cell_acc[i] = 0;
    pos_row = 0;
    pos_col = 0;
    next_band = 0;
    next_cell = 0;
  endfunction

  function automatic bit locate(ref int unsigned edges[GRID_LIM+1], input int unsigned pos,
                                output int unsigned slot);
    slot = 0;
    if (pos < edges[0] || pos >= edges[frame_n]) return 0;
    for (int i = 0; i < frame_n; i++)
      if (pos < edges[i+1]) begin
        slot = i;
        return 1;
      end
    return 0;
  endfunction

  // Accumulates one sample and queues the cells that it completes.
  function automatic void pool_sample(logic [SAMPLE_W-1:0] value, logic first);
    int unsigned k, l, rows_done, reported;
    longint unsigned area;
    cell_report_t rep;
    reported = 0;
    if (first) restart_frame();
    if (locate(row_edge, pos_row, l) && locate(col_edge, pos_col, k))
      cell_acc[l*GRID_LIM + k] += value;
    rows_done = pos_row + ((pos_col + 1 >= frame_w) ? 1 : 0);
    while (reported < RESULT_CAP && next_band < frame_n &&
           row_edge[next_band+1] <= rows_done) begin
      area = longint'(row_edge[next_band+1] - row_edge[next_band]) *
             longint'(col_edge[next_cell+1] - col_edge[next_cell]);
      rep.empty = (area == 0);
      rep.mean = (area == 0) ? '0 : SAMPLE_W'(cell_acc[next_band*GRID_LIM + next_cell] / area);
      rep.index = INDEX_W'(next_cell * frame_n + next_band);
      rep.band_end = (next_cell + 1 == frame_n);
      rep.frame_end = (next_cell + 1 == frame_n) && (next_band + 1 == frame_n);
      report_q = {report_q, rep};
      reported++;
      next_cell++;
      if (next_cell >= frame_n) begin
        next_cell = 0;
        next_band++;
      end
    end
    if (pos_col + 1 >= frame_w) begin
      pos_col = 0;
      if (pos_row + 1 >= frame_h) restart_frame();
      else pos_row++;
    end else begin
      pos_col++;
    end
  endfunction

  always @(posedge clk) begin
    cell_report_t want;
    if (rst) begin
      reg_width = RST_IMAGE_WIDTH;
      reg_height = RST_IMAGE_HEIGHT;
      reg_grid = RST_GRID_SIZE;
      reg_col_shift = '0;
      reg_row_shift = '0;
      restart_frame();
      report_q.delete();
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:  reg_width = cfg_data;
          REG_IMAGE_HEIGHT: reg_height = cfg_data;
          REG_GRID_SIZE:    reg_grid = cfg_data[4:0];
          REG_COL_SHIFT:    reg_col_shift = cfg_data;
          REG_ROW_SHIFT:    reg_row_shift = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) pool_sample(in_ch.sample, in_ch.frame_start);
      if (out_ch.valid && out_ch.ready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected cell transaction, actual mean %h index %0d",
                   $time, out_ch.cell_mean, out_ch.cell_index);
          fail_count <= fail_count + 1;
        end else begin
          want = report_q.pop_front();
          if (want.mean !== out_ch.cell_mean || want.index !== out_ch.cell_index ||
              want.empty !== out_ch.empty_cell || want.band_end !== out_ch.last_in_band ||
              want.frame_end !== out_ch.last_in_frame) begin
            $display("%0t: cell mismatch, expected mean %h idx %0d empty %b band %b frame %b",
                     $time, want.mean, want.index, want.empty, want.band_end, want.frame_end);
            $display("%0t:                actual mean %h idx %0d empty %b band %b frame %b",
                     $time, out_ch.cell_mean, out_ch.cell_index, out_ch.empty_cell,
                     out_ch.last_in_band, out_ch.last_in_frame);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    cells_pending <= report_q.size();
  end

endmodule

// ----- dv/block_mean_pooling_grid_top_tb.sv -----
`timescale 1ns / 1ps
module block_mean_pooling_grid_top_tb;
  import bmp_pkg::*;

  localparam int CYCLE_LIMIT  = 3000000;
  localparam int SETTLE_WAIT  = 3000;
  localparam int RANDOM_ITEMS = 90;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int fail_count, cells_pending;
  int cycle_count = 0;
  int burst_left = 0;
  int random_sent = 0;
  bit hold_request = 0;
  int hold_left = 0;
  int ready_pct = 100;

  bmp_in_if samples ();
  bmp_out_if cells ();

  block_mean_pooling_grid_top DUT (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .samples(samples.sink), .cells(cells.source)
  );

  block_mean_pooling_grid_checker checker_i (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_ch(samples), .out_ch(cells), .fail_count(fail_count), .cells_pending(cells_pending)
  );

  always #10 clk = ~clk;

  initial begin
    samples.valid = 1'b0;
    samples.sample = '0;
    samples.frame_start = 1'b0;
    cells.ready = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** block_mean_pooling_grid_top: FAILED **");
      $finish;
    end
  end

  // Receiver: a random stall pattern of changing density,
  // plus one long hold-off that lets the block back up into its input.
  always @(posedge clk) begin
    if (cycle_count % 300 == 0) ready_pct = ($urandom_range(0, 3) == 0) ? 100 :
                                            $urandom_range(20, 90);
    if (rst) begin
      cells.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      cells.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = 900;
      cells.ready <= 1'b0;
    end else begin
      cells.ready <= ($urandom_range(1, 100) <= ready_pct);
    end
  end

  task automatic send_sample(logic [SAMPLE_W-1:0] value, logic first);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        samples.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    samples.valid <= 1'b1;
    samples.sample <= value;
    samples.frame_start <= first;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    burst_left--;
  endtask

  // Waits for every cell to drain and for the block to finish its edge pass.
  task automatic wait_idle();
    samples.valid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic set_geometry(logic [10:0] w, logic [10:0] h, logic [10:0] n,
                              logic [10:0] cs, logic [10:0] rs);
    logic [10:0] vals[5];
    logic [CFG_IDX_W-1:0] idx[5];
    vals = '{w, h, n, cs, rs};
    idx = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_GRID_SIZE, REG_COL_SHIFT, REG_ROW_SHIFT};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= vals[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return SAMPLE_W'($urandom());
    endcase
  endfunction

  // Sends whole frames; a few carry a stray frame start or stop early.
  task automatic send_frames(int w, int h, int frames, bit counted);
    int total, stop_at;
    for (int f = 0; f < frames; f++) begin
      total = w * h;
      stop_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, total) : total;
      for (int i = 0; i < stop_at; i++) begin
        send_sample(pick_sample(), (i == 0) || ($urandom_range(0, 60) == 0));
        if (counted) begin
          random_sent++;
          if (random_sent == 60) hold_request = 1;
        end
      end
    end
  endtask

  function automatic logic [10:0] pick_shift(int ext);
    if ($urandom_range(0, 5) == 0) return 11'($urandom());
    return 11'($signed($urandom_range(0, 2*ext + 4)) - ext - 2);
  endfunction

  initial begin
    int w, h;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // An out-of-range index write, then extreme samples on a small even grid.
    set_geometry(11'd4, 11'd4, 11'd2, 11'd0, 11'd0);
    cfg_we <= 1'b1;
    cfg_index <= REG_UNUSED;
    cfg_data <= 11'h7FF;
    @(posedge clk);
    cfg_we <= 1'b0;
    for (int i = 0; i < 16; i++)
      send_sample((i % 3 == 0) ? '1 : ((i % 3 == 1) ? '0 : 24'hA5A5A5), i == 0);
    wait_idle();

    // Grid finer than the window, so some cells are empty.
    set_geometry(11'd5, 11'd3, 11'd16, 11'h7FE, 11'd1);
    send_frames(5, 3, 1, 0);
    wait_idle();
    // Zero registers act as one.
    set_geometry(11'd0, 11'd0, 11'd0, 11'd0, 11'd0);
    send_frames(1, 1, 3, 0);
    wait_idle();
    // Shifts beyond the size leave every cell empty.
    set_geometry(11'd8, 11'd6, 11'd3, 11'd512, 11'h600);
    send_frames(8, 6, 1, 0);
    wait_idle();
    // Saturating width and grid, with a one-row frame that is cut off before its end.
    set_geometry(11'h7FF, 11'd1, 11'h1F, 11'h400, 11'd0);
    for (int i = 0; i < 20; i++) send_sample(pick_sample(), i == 0);
    wait_idle();
    // A tall one-column frame, far enough to close its first band.
    set_geometry(11'd1, 11'd1024, 11'd16, 11'd0, 11'h7FF);
    for (int i = 0; i < 70; i++) send_sample(pick_sample(), i == 0);
    wait_idle();

    while (random_sent < RANDOM_ITEMS) begin
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      set_geometry(11'(w), 11'(h), 11'($urandom_range(1, 16)), pick_shift(w), pick_shift(h));
      send_frames(w, h, $urandom_range(1, 2), 1);
      wait_idle();
    end

    if (fail_count == 0) begin
      $display("** block_mean_pooling_grid_top: PASSED **");
    end else begin
      $display("** block_mean_pooling_grid_top: FAILED **");
    end
    $finish;
  end

endmodule
